// ----- rtl/spm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier package
// Operation codes and fixed point helpers shared by the multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

	localparam int COEFF_W = 32;
	localparam int PROD_W  = 64;

	// Operation codes of an input item.
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_MUL    = 2'd2;

	typedef logic signed [COEFF_W-1:0] coeff_t;

	// Rounds a Q32.32 product half up to Q16.16 and saturates it.
	function automatic coeff_t fx_round(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		logic signed [PROD_W-17:0] q;
		coeff_t r;
		t = p + 64'sd32768;
		q = t[PROD_W-1:16];
		if (&q[PROD_W-17:COEFF_W-1] || ~|q[PROD_W-17:COEFF_W-1]) begin
			r = q[COEFF_W-1:0];
		end else if (q[PROD_W-17]) begin
			r = {1'b1, {(COEFF_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COEFF_W-1){1'b1}}};
		end
		return r;
	endfunction

	// Adds two coefficients and saturates the sum.
	function automatic coeff_t sat_add(input coeff_t x, input coeff_t y);
		logic [COEFF_W:0] s;
		coeff_t r;
		s = {x[COEFF_W-1], x} + {y[COEFF_W-1], y};
		if (s[COEFF_W] == s[COEFF_W-1]) begin
			r = s[COEFF_W-1:0];
		end else if (s[COEFF_W]) begin
			r = {1'b1, {(COEFF_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(COEFF_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/spm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                     wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data is registered; a read of the entry being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/sparse_polynomial_multiplier.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier
// Multiplies two loaded sparse polynomials into a sorted, merged term table; an empty operand passes the other through.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Op 0 and op 1 store a
// term in operand A or B with busy staying low, so loads can come every
// cycle; loads into a full operand and op 3 are dropped.
// Op 2 runs the multiply and raises busy unless both operands are empty.
// Every pairwise product goes through the read, the multiply and the
// rounding, and then walks the product table through its single read port,
// reading and then comparing each entry looked at, before it is added in
// place or appended. The table is then emitted in descending exponent order
// by selection: each result costs one pass over the table. Each result
// shows on the result ports for one cycle with result_valid high; last
// marks the final one. With one operand empty, the other operand's terms
// go out in load order at one per cycle; with both empty, a single result
// with empty_res set follows in the cycle after the item is taken. The
// receiver cannot stall the block. Reset clears all counts; the term
// stores need no clearing since only entries below a count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_multiplier
	import spm_pkg::*;
#(
	parameter int MAX_TERMS = 8,
	parameter int EXP_BITS  = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         op,
	input  wire logic signed [31:0] term_coeff,
	input  wire logic [7:0]         term_exp,
	output logic                    result_valid,
	output logic signed [31:0]      out_coeff,
	output logic [8:0]              out_exp,
	output logic                    last,
	output logic                    empty_res
);

	localparam int PD  = MAX_TERMS * MAX_TERMS;
	localparam int AW  = MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1;
	localparam int CW  = $clog2(MAX_TERMS + 1);
	localparam int PAW = PD > 1 ? $clog2(PD) : 1;
	localparam int PCW = $clog2(PD + 1);
	localparam int EW  = EXP_BITS;
	localparam int TW  = COEFF_W + EW;
	localparam int PW  = COEFF_W + EW + 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LIST = 3'd1;
	localparam logic [2:0] ST_MRD  = 3'd2;
	localparam logic [2:0] ST_MMUL = 3'd3;
	localparam logic [2:0] ST_MRND = 3'd4;
	localparam logic [2:0] ST_SRD  = 3'd5;
	localparam logic [2:0] ST_SCMP = 3'd6;
	localparam logic [2:0] ST_SCAN = 3'd7;

	logic [2:0]     state_q;
	logic [CW-1:0]  a_cnt_q, b_cnt_q;
	logic [PCW-1:0] p_cnt_q, k_q, e_cnt_q;
	logic [AW-1:0]  i_q, j_q;
	logic           src_b_q;
	logic           lv_s1_q, llast_s1_q;
	logic           sv_s1_q, slast_s1_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [EW:0]    pe_s1, pe_q;
	coeff_t         pc_q;
	logic           first_q, have_q;
	logic [EW:0]    prev_q, best_e_q;
	coeff_t         best_c_q;
	logic           res_valid_q, last_q, empty_q;
	coeff_t         out_c_q;
	logic [8:0]     out_e_q;

	logic           accept;
	logic [EW-1:0]  exp_in;
	logic           a_we, b_we, p_we;
	logic [AW-1:0]  a_raddr, b_raddr;
	logic [PAW-1:0] p_waddr, p_raddr;
	logic [PW-1:0]  p_wdata, p_rdata;
	logic [TW-1:0]  a_rdata, b_rdata;
	coeff_t         a_rc, b_rc, p_rc;
	logic [EW-1:0]  a_re, b_re;
	logic [EW:0]    p_re;
	logic [CW-1:0]  list_n;
	logic           pair_last_j, pair_last_i;
	logic           cand_ok, take;
	coeff_t         nb_c;
	logic [EW:0]    nb_e;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE) || lv_s1_q;
	assign exp_in = EW'(term_exp);

	assign a_rc = a_rdata[TW-1:EW];
	assign a_re = a_rdata[EW-1:0];
	assign b_rc = b_rdata[TW-1:EW];
	assign b_re = b_rdata[EW-1:0];
	assign p_rc = p_rdata[PW-1:EW+1];
	assign p_re = p_rdata[EW:0];

	assign list_n      = src_b_q ? b_cnt_q : a_cnt_q;
	assign pair_last_j = (CW'(j_q) + CW'(1)) == b_cnt_q;
	assign pair_last_i = (CW'(i_q) + CW'(1)) == a_cnt_q;

	// Selection of the largest exponent below the one emitted last.
	assign cand_ok = first_q || (p_re < prev_q);
	assign take    = cand_ok && (!have_q || (p_re > best_e_q));
	assign nb_c    = take ? p_rc : best_c_q;
	assign nb_e    = take ? p_re : best_e_q;

	// Memory port control.
	always_comb begin
		a_we    = accept && (op == OP_LOAD_A) && (a_cnt_q < CW'(MAX_TERMS));
		b_we    = accept && (op == OP_LOAD_B) && (b_cnt_q < CW'(MAX_TERMS));
		a_raddr = (state_q == ST_LIST) ? k_q[AW-1:0] : i_q;
		b_raddr = (state_q == ST_LIST) ? k_q[AW-1:0] : j_q;
		p_raddr = k_q[PAW-1:0];
		p_we    = 1'b0;
		p_waddr = k_q[PAW-1:0];
		p_wdata = {pc_q, pe_q};
		if (state_q == ST_SRD && k_q == p_cnt_q) begin
			p_we    = 1'b1;
			p_waddr = p_cnt_q[PAW-1:0];
		end
		if (state_q == ST_SCMP && p_re == pe_q) begin
			p_we    = 1'b1;
			p_wdata = {sat_add(p_rc, pc_q), pe_q};
		end
	end

	spm_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_a_ram (
		.clk(clk), .we(a_we), .waddr(a_cnt_q[AW-1:0]), .wdata({term_coeff, exp_in}),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	spm_ram #(.WIDTH(TW), .DEPTH(MAX_TERMS)) u_b_ram (
		.clk(clk), .we(b_we), .waddr(b_cnt_q[AW-1:0]), .wdata({term_coeff, exp_in}),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	spm_ram #(.WIDTH(PW), .DEPTH(PD)) u_p_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	// Sequencer for loads, the product walk and the emission passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			a_cnt_q     <= '0;
			b_cnt_q     <= '0;
			p_cnt_q     <= '0;
			k_q         <= '0;
			e_cnt_q     <= '0;
			i_q         <= '0;
			j_q         <= '0;
			src_b_q     <= 1'b0;
			lv_s1_q     <= 1'b0;
			llast_s1_q  <= 1'b0;
			sv_s1_q     <= 1'b0;
			slast_s1_q  <= 1'b0;
			prod_s1     <= '0;
			pe_s1       <= '0;
			pe_q        <= '0;
			pc_q        <= '0;
			first_q     <= 1'b0;
			have_q      <= 1'b0;
			prev_q      <= '0;
			best_e_q    <= '0;
			best_c_q    <= '0;
			res_valid_q <= 1'b0;
			last_q      <= 1'b0;
			empty_q     <= 1'b0;
			out_c_q     <= '0;
			out_e_q     <= '0;
		end else begin
			res_valid_q <= 1'b0;
			lv_s1_q     <= 1'b0;
			sv_s1_q     <= 1'b0;

			// A list read from the previous cycle becomes a result.
			if (lv_s1_q) begin
				res_valid_q <= 1'b1;
				last_q      <= llast_s1_q;
				empty_q     <= 1'b0;
				out_c_q     <= src_b_q ? b_rc : a_rc;
				out_e_q     <= 9'(src_b_q ? b_re : a_re);
			end

			case (state_q)
				ST_IDLE: begin
					if (a_we) begin
						a_cnt_q <= a_cnt_q + CW'(1);
					end
					if (b_we) begin
						b_cnt_q <= b_cnt_q + CW'(1);
					end
					if (accept && op == OP_MUL) begin
						k_q     <= '0;
						i_q     <= '0;
						j_q     <= '0;
						p_cnt_q <= '0;
						if (a_cnt_q == '0 && b_cnt_q == '0) begin
							res_valid_q <= 1'b1;
							last_q      <= 1'b1;
							empty_q     <= 1'b1;
							out_c_q     <= '0;
							out_e_q     <= '0;
						end else if (a_cnt_q == '0 || b_cnt_q == '0) begin
							src_b_q <= (a_cnt_q == '0);
							state_q <= ST_LIST;
						end else begin
							state_q <= ST_MRD;
						end
					end
				end
				ST_LIST: begin
					lv_s1_q    <= 1'b1;
					llast_s1_q <= (k_q + PCW'(1)) == PCW'(list_n);
					k_q        <= k_q + PCW'(1);
					if ((k_q + PCW'(1)) == PCW'(list_n)) begin
						a_cnt_q <= '0;
						b_cnt_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_MRD: begin
					state_q <= ST_MMUL;
				end
				ST_MMUL: begin
					prod_s1 <= a_rc * b_rc;
					pe_s1   <= {1'b0, a_re} + {1'b0, b_re};
					state_q <= ST_MRND;
				end
				ST_MRND: begin
					pc_q    <= fx_round(prod_s1);
					pe_q    <= pe_s1;
					k_q     <= '0;
					state_q <= ST_SRD;
				end
				ST_SRD, ST_SCMP: begin
					if ((state_q == ST_SRD && k_q == p_cnt_q) ||
					    (state_q == ST_SCMP && p_re == pe_q)) begin
						if (state_q == ST_SRD) begin
							p_cnt_q <= p_cnt_q + PCW'(1);
						end
						// Next pair, or start the emission passes.
						if (pair_last_j) begin
							j_q <= '0;
							if (pair_last_i) begin
								k_q      <= '0;
								e_cnt_q  <= '0;
								first_q  <= 1'b1;
								have_q   <= 1'b0;
								state_q  <= ST_SCAN;
							end else begin
								i_q     <= i_q + AW'(1);
								state_q <= ST_MRD;
							end
						end else begin
							j_q     <= j_q + AW'(1);
							state_q <= ST_MRD;
						end
					end else if (state_q == ST_SRD) begin
						state_q <= ST_SCMP;
					end else begin
						k_q     <= k_q + PCW'(1);
						state_q <= ST_SRD;
					end
				end
				ST_SCAN: begin
					if (k_q != p_cnt_q) begin
						sv_s1_q    <= 1'b1;
						slast_s1_q <= (k_q + PCW'(1)) == p_cnt_q;
						k_q        <= k_q + PCW'(1);
					end
					if (sv_s1_q) begin
						best_c_q <= nb_c;
						best_e_q <= nb_e;
						have_q   <= have_q || take;
						if (slast_s1_q) begin
							res_valid_q <= 1'b1;
							last_q      <= (e_cnt_q + PCW'(1)) == p_cnt_q;
							empty_q     <= 1'b0;
							out_c_q     <= nb_c;
							out_e_q     <= 9'(nb_e);
							prev_q      <= nb_e;
							first_q     <= 1'b0;
							have_q      <= 1'b0;
							e_cnt_q     <= e_cnt_q + PCW'(1);
							k_q         <= '0;
							if ((e_cnt_q + PCW'(1)) == p_cnt_q) begin
								a_cnt_q <= '0;
								b_cnt_q <= '0;
								p_cnt_q <= '0;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign out_coeff    = out_c_q;
	assign out_exp      = out_e_q;
	assign last         = last_q;
	assign empty_res    = empty_q;

endmodule

`default_nettype wire

// ----- dv/tb_sparse_polynomial_multiplier.sv -----
// ----------------------------------------------------------------------------
// Sparse polynomial multiplier testbench
// Loads operand terms, issues multiply items and checks every result term
// against a predicted, merged and saturated product table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sparse_polynomial_multiplier;
	import spm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NTERMS = 8;

	// Operation code that the block ignores.
	localparam logic [1:0] OP_NONE = 2'd3;

	// Expected result term.
	typedef struct packed {
		logic signed [31:0] coeff;
		logic [8:0]         exp;
		logic               last;
		logic               empty;
	} term_res_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         op;
	logic signed [31:0] term_coeff;
	logic [7:0]         term_exp;
	logic               result_valid;
	logic signed [31:0] out_coeff;
	logic [8:0]         out_exp;
	logic               last;
	logic               empty_res;

	sparse_polynomial_multiplier dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.term_coeff(term_coeff), .term_exp(term_exp),
		.result_valid(result_valid), .out_coeff(out_coeff), .out_exp(out_exp),
		.last(last), .empty_res(empty_res)
	);

	// Predictor state: the two operands as loaded.
	logic signed [31:0] a_c [NTERMS];
	logic [7:0]         a_e [NTERMS];
	int                 a_n;
	logic signed [31:0] b_c [NTERMS];
	logic [7:0]         b_e [NTERMS];
	int                 b_n;

	term_res_t expected_terms[$];
	int        mismatches;
	int        terms_seen;
	int        items_sent;
	int        mul_items;
	bit        idle_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Timeout after %0d items.", items_sent);
		$display("RESULT: ERROR");
		$finish;
	end

	// Saturates a wide value to Q16.16.
	function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// Q16.16 product rounded half up, then saturated.
	function automatic logic signed [31:0] qmul(input logic signed [31:0] x,
			input logic signed [31:0] y);
		logic signed [65:0] p;
		p = $signed({{34{x[31]}}, x}) * $signed({{34{y[31]}}, y}) + 66'sd32768;
		return clamp32(p >>> 16);
	endfunction

	// Works out the result terms of one item and updates the operands.
	task automatic predict_item(input logic [1:0] o, input logic signed [31:0] c,
			input logic [7:0] e);
		logic signed [31:0] tc [$];
		logic [8:0]         te [$];
		logic signed [31:0] pc;
		logic [8:0]         pe;
		int                 k;
		term_res_t          r;
		if (o == OP_LOAD_A) begin
			if (a_n < NTERMS) begin
				a_c[a_n] = c; a_e[a_n] = e; a_n++;
			end
		end else if (o == OP_LOAD_B) begin
			if (b_n < NTERMS) begin
				b_c[b_n] = c; b_e[b_n] = e; b_n++;
			end
		end else if (o == OP_MUL) begin
			mul_items++;
			if (a_n == 0 && b_n == 0) begin
				tc.push_back(0); te.push_back(0);
			end else if (a_n == 0) begin
				for (int j = 0; j < b_n; j++) begin
					tc.push_back(b_c[j]); te.push_back(b_e[j]);
				end
			end else if (b_n == 0) begin
				for (int i = 0; i < a_n; i++) begin
					tc.push_back(a_c[i]); te.push_back(a_e[i]);
				end
			end else begin
				// Merge each product into the descending table.
				for (int i = 0; i < a_n; i++) begin
					for (int j = 0; j < b_n; j++) begin
						pc = qmul(a_c[i], b_c[j]);
						pe = {1'b0, a_e[i]} + {1'b0, b_e[j]};
						k = 0;
						while (k < te.size() && te[k] > pe) k++;
						if (k < te.size() && te[k] == pe) begin
							tc[k] = clamp32(66'(tc[k]) + 66'(pc));
						end else begin
							tc.insert(k, pc); te.insert(k, pe);
						end
					end
				end
			end
			for (int i = 0; i < tc.size(); i++) begin
				r.coeff = tc[i];
				r.exp = te[i];
				r.last = (i == tc.size() - 1);
				r.empty = (a_n == 0 && b_n == 0);
				expected_terms.push_back(r);
			end
			a_n = 0;
			b_n = 0;
		end
	endtask

	// Sends one item and predicts its results at acceptance. Start stays high
	// until the next item or an idle stretch replaces it at a falling edge.
	task automatic send_item(input logic [1:0] o, input logic signed [31:0] c,
			input logic [7:0] e);
		int gap;
		if (idle_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op <= o;
		term_coeff <= c;
		term_exp <= e;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_item(o, c, e);
		items_sent++;
		@(negedge clk);
	endtask

	// Waits until all predicted results have come and the block is idle.
	task automatic drain();
		start <= 1'b0;
		while (expected_terms.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// Checks each result against the oldest expectation.
	always @(posedge clk) begin
		term_res_t x;
		if (arst_n && result_valid) begin
			terms_seen++;
			if (expected_terms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: coeff %h exp %0d", out_coeff, out_exp);
			end else begin
				x = expected_terms.pop_front();
				if (out_coeff !== x.coeff || out_exp !== x.exp || last !== x.last
						|| empty_res !== x.empty) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: exp coeff %h exp %0d last %b empty %b, got %h %0d %b %b",
							x.coeff, x.exp, x.last, x.empty, out_coeff, out_exp, last,
							empty_res);
				end
			end
		end
	end

	// Extremes, both empty, one empty, full operands and the unused op.
	task automatic test_directed();
		send_item(OP_MUL, 0, 0);
		send_item(OP_LOAD_A, 32'sh7fffffff, 8'hff);
		send_item(OP_MUL, 0, 0);
		send_item(OP_LOAD_B, 32'sh80000000, 8'h00);
		send_item(OP_LOAD_B, 32'sh00010000, 8'hff);
		send_item(OP_MUL, 32'shffffffff, 8'hff);
		send_item(OP_LOAD_A, 32'sh80000000, 8'hff);
		send_item(OP_LOAD_A, 32'sh7fffffff, 8'h00);
		send_item(OP_LOAD_B, 32'sh80000000, 8'hff);
		send_item(OP_LOAD_B, 32'sh7fffffff, 8'h00);
		send_item(OP_NONE, 32'sh12345678, 8'h55);
		send_item(OP_MUL, 0, 0);
		// Fill A beyond its depth; B holds a cancelling pair.
		for (int i = 0; i < NTERMS + 2; i++) send_item(OP_LOAD_A, 32'sh00018000, 8'(i));
		send_item(OP_LOAD_B, 32'sh00010000, 8'd1);
		send_item(OP_LOAD_B, 32'shffff0000, 8'd0);
		send_item(OP_MUL, 0, 0);
		drain();
	endtask

	// Random polynomials, mostly small, a few full.
	task automatic test_random(input int n_items);
		int na, nb, sent;
		sent = 0;
		while (sent < n_items) begin
			na = ($urandom_range(0, 7) == 0) ? NTERMS + 1 : $urandom_range(0, 4);
			nb = ($urandom_range(0, 7) == 0) ? NTERMS + 1 : $urandom_range(0, 4);
			for (int i = 0; i < na + nb; i++) begin
				send_item((i < na) ? OP_LOAD_A : OP_LOAD_B,
					($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 32'h3ffff))
						- 32'sh20000,
					($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)));
			end
			if ($urandom_range(0, 5) == 0) begin
				send_item(OP_NONE, $urandom, 8'($urandom));
				sent++;
			end
			send_item(OP_MUL, $urandom, 8'($urandom));
			sent += na + nb + 1;
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_LOAD_A;
		term_coeff = 0;
		term_exp = 0;
		a_n = 0;
		b_n = 0;
		mismatches = 0;
		terms_seen = 0;
		items_sent = 0;
		mul_items = 0;
		idle_gaps = 1'b1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(55);
		idle_gaps = 1'b0;
		test_random(22);
		$display("Sent %0d items including %0d multiplies; checked %0d result terms.",
			items_sent, mul_items, terms_seen);
		if (mismatches == 0 && expected_terms.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results missing.", mismatches,
				expected_terms.size());
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/spm_pkg.sv
rtl/spm_ram.sv
rtl/sparse_polynomial_multiplier.sv
dv/tb_sparse_polynomial_multiplier.sv
